FILE: hw/rtl/acsp_pkg.sv
// Package with shared types and constants of the animation clip stream parser.
package acsp_pkg;

  // Parse phases of the front end.
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_BONE   = 4'd1,
    PH_CNT_S  = 4'd2,
    PH_KEY_S  = 4'd3,
    PH_CNT_R  = 4'd4,
    PH_KEY_R  = 4'd5,
    PH_CNT_P  = 4'd6,
    PH_KEY_P  = 4'd7,
    PH_DONE   = 4'd8,
    PH_DRAIN  = 4'd9
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_SCALE    = 2'd0;
  localparam logic [1:0] KIND_ROTATION = 2'd1;
  localparam logic [1:0] KIND_POSITION = 2'd2;
  localparam logic [1:0] KIND_STATUS   = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_TYPE      = 4'd3;
  localparam logic [3:0] ST_ZERO      = 4'd4;
  localparam logic [3:0] ST_TRUNC     = 4'd5;
  localparam logic [3:0] ST_ROTATION  = 4'd6;
  localparam logic [3:0] ST_TRAILING  = 4'd7;
  localparam logic [3:0] ST_SIZE      = 4'd8;
  localparam logic [3:0] ST_NO_KEYS   = 4'd9;

  localparam logic [4:0] HDR_LEN    = 5'd26;
  localparam logic [7:0] TYPE_BYTE  = 8'h02;
  localparam logic [31:0] MAGIC     = 32'h2052_4150;
  localparam logic [49:0] NORM_MAX  = {50{1'b1}};
  localparam logic [49:0] NORM_LO   = 50'd15099494 << 24;
  localparam logic [49:0] NORM_HI   = 50'd18454938 << 24;

  // Request from front end to back end: a finished key or a file status.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bone_id;
    logic [15:0] time_ms;
    logic [15:0] h0;
    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] h3;
    logic [3:0]  status;
    logic [7:0]  version;
  } req_t;

  // Exact half to single conversion.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  sh;
    logic [10:0] m;
    logic [31:0] r;
    sign = {h[15], 31'd0};
    ex   = h[14:10];
    man  = h[9:0];
    sh   = 4'd0;
    for (int k = 9; k >= 0; k--) begin
      if (man[k] && sh == 4'd0) sh = 4'(10 - k);
    end
    m = {1'b0, man} << sh;
    if (ex == 5'd0) begin
      if (man == 10'd0) r = sign;
      else r = sign | ({24'd0, 8'(8'd113 - {4'd0, sh})} << 23) | ({22'd0, m[9:0]} << 13);
    end else if (ex == 5'd31) begin
      r = sign | 32'h7F80_0000 | ({22'd0, man} << 13);
    end else begin
      r = sign | ({24'd0, 8'({3'd0, ex} + 8'd112)} << 23) | ({22'd0, man} << 13);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/acsp_front.sv
// Front end: byte parser that classifies bytes and issues key and status requests.
module acsp_front import acsp_pkg::*; #(
  parameter int LENGTH_BITS = 34
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  input  logic       accept,
  output logic       req_valid,
  output logic       req_two,
  output req_t       req0,
  output req_t       req1
);

  // Width that holds both the byte count and the largest expected file size.
  localparam int EXP_BITS = (LENGTH_BITS > 33) ? LENGTH_BITS + 1 : 34;

  phase_t             phase, phase_next;
  logic [4:0]         bis, bis_next;
  logic [7:0]         hver, hver_next;
  logic [15:0]        bone_total, bone_total_next;
  logic [15:0]        bones_left, bones_left_next;
  logic [31:0]        dsize, dsize_next;
  logic [15:0]        keys_left, keys_left_next;
  logic [31:0]        cur_bone, cur_bone_next;
  logic [7:0]         kb [10];
  logic [LENGTH_BITS-1:0] bcount, bcount_next;
  logic [49:0]        norm, norm_next;
  logic               any_key, any_key_next;
  logic [3:0]         ferr, ferr_next;
  logic               key_out;
  req_t               key_req;
  logic [3:0]         st;

  // Square of one half for the rotation norm (one per two bytes).
  logic [15:0] sq_h;
  logic [49:0] sq;
  logic [24:0] sq_v;
  logic [50:0] norm_add;
  always_comb begin
    sq_h = {data_byte, kb[4'(bis - 5'd1)]};
    sq_v = (sq_h[14:10] == 5'd0) ? {15'd0, sq_h[9:0]} :
           25'({14'd0, 1'b1, sq_h[9:0]} << (sq_h[14:10] - 5'd1));
    sq = (sq_h[14:10] > 5'd15) ? NORM_MAX : {25'd0, sq_v} * {25'd0, sq_v};
    norm_add = {1'b0, ((bis == 5'd3) ? 50'd0 : norm)} + {1'b0, sq};
  end

  // End-of-list transition helper values.
  function automatic phase_t after_list(input phase_t p, input logic [15:0] bl);
    if (p == PH_CNT_S || p == PH_KEY_S) return PH_CNT_R;
    if (p == PH_CNT_R || p == PH_KEY_R) return PH_CNT_P;
    return (bl == 16'd1) ? PH_DONE : PH_BONE;
  endfunction

  // Next-state logic for one accepted byte.
  always_comb begin
    logic [15:0] bt;
    logic [15:0] kl;
    logic [4:0]  len;
    logic        rot;
    phase_next = phase; bis_next = bis; hver_next = hver;
    bone_total_next = bone_total; bones_left_next = bones_left;
    dsize_next = dsize; keys_left_next = keys_left; cur_bone_next = cur_bone;
    bcount_next = (&bcount) ? bcount : bcount + 1'b1;
    norm_next = norm; any_key_next = any_key; ferr_next = ferr;
    key_out = 1'b0;
    bt = {data_byte, bone_total[7:0]};
    kl = {data_byte, keys_left[7:0]};
    rot = (phase == PH_KEY_R);
    len = rot ? 5'd10 : 5'd8;
    case (phase)
      PH_HEADER: begin
        if (bis < 5'd4 && data_byte != MAGIC[8*bis[1:0] +: 8] && ferr == ST_OK)
          ferr_next = ST_MAGIC;
        if (bis == 5'd4 && data_byte != TYPE_BYTE && ferr == ST_OK) ferr_next = ST_TYPE;
        if (bis == 5'd5) hver_next = data_byte;
        if (bis == 5'h10) bone_total_next = {8'd0, data_byte};
        if (bis == 5'h11) begin
          bone_total_next = bt;
          if (bt == 16'd0 && ferr == ST_OK) ferr_next = ST_ZERO;
        end
        if (bis >= 5'h16 && bis <= 5'h19)
          dsize_next = dsize | ({24'd0, data_byte} << (8 * (bis - 5'h16)));
        bis_next = bis + 5'd1;
        if (bis == HDR_LEN - 5'd1) begin
          bis_next = 5'd0;
          bones_left_next = bone_total;
          phase_next = (ferr_next != ST_OK) ? PH_DRAIN : PH_BONE;
        end
      end
      PH_BONE: begin
        cur_bone_next = cur_bone | ({24'd0, data_byte} << (8 * bis[1:0]));
        bis_next = bis + 5'd1;
        if (bis == 5'd3) begin
          bis_next = 5'd0;
          phase_next = PH_CNT_S;
        end
      end
      PH_CNT_S, PH_CNT_R, PH_CNT_P: begin
        if (bis == 5'd0) begin
          keys_left_next = {8'd0, data_byte};
          bis_next = 5'd1;
        end else begin
          keys_left_next = kl;
          bis_next = 5'd0;
          if (kl == 16'd0) begin
            phase_next = after_list(phase, bones_left);
            if (phase == PH_CNT_P) bones_left_next = bones_left - 16'd1;
          end else begin
            phase_next = phase_t'(phase + 4'd1);
          end
        end
      end
      PH_KEY_S, PH_KEY_R, PH_KEY_P: begin
        if (rot && bis >= 5'd3 && bis[0])
          norm_next = norm_add[50] ? NORM_MAX : norm_add[49:0];
        bis_next = bis + 5'd1;
        if (bis == len - 5'd1) begin
          bis_next = 5'd0;
          if (rot && (norm_next < NORM_LO || norm_next > NORM_HI)) begin
            ferr_next = ST_ROTATION;
            phase_next = PH_DRAIN;
          end else begin
            key_out = 1'b1;
            any_key_next = 1'b1;
            keys_left_next = keys_left - 16'd1;
            if (keys_left == 16'd1) begin
              phase_next = after_list(phase, bones_left);
              if (phase == PH_KEY_P) bones_left_next = bones_left - 16'd1;
            end
          end
        end
      end
      PH_DONE: begin
        ferr_next = ST_TRAILING;
        phase_next = PH_DRAIN;
      end
      default: ;
    endcase
    if (phase_next == PH_BONE && bis_next == 5'd0) cur_bone_next = 32'd0;
  end

  // Key request built from the gathered bytes plus the current byte.
  always_comb begin
    logic [7:0] b [10];
    for (int k = 0; k < 10; k++) b[k] = kb[k];
    b[bis[3:0]] = data_byte;
    key_req = '0;
    key_req.kind = (phase == PH_KEY_S) ? KIND_SCALE :
                   (phase == PH_KEY_R) ? KIND_ROTATION : KIND_POSITION;
    key_req.bone_id = cur_bone;
    key_req.time_ms = {b[1], b[0]};
    key_req.h0 = {b[3], b[2]};
    key_req.h1 = {b[5], b[4]};
    key_req.h2 = {b[7], b[6]};
    key_req.h3 = (phase == PH_KEY_R) ? {b[9], b[8]} : 16'd0;
  end

  // Final status from the state after this byte.
  always_comb begin
    logic [EXP_BITS-1:0] expect_size;
    expect_size = EXP_BITS'(HDR_LEN) + EXP_BITS'(bone_total_next) * EXP_BITS'(10)
                  + EXP_BITS'(dsize_next);
    if (phase_next == PH_HEADER && phase == PH_HEADER) st = ST_SHORT;
    else if (ferr_next >= ST_MAGIC && ferr_next <= ST_ZERO) st = ferr_next;
    else if ((&bcount_next) || EXP_BITS'(bcount_next) != expect_size) st = ST_SIZE;
    else if (ferr_next != ST_OK) st = ferr_next;
    else if (phase_next != PH_DONE) st = ST_TRUNC;
    else if (!any_key_next) st = ST_NO_KEYS;
    else st = ST_OK;
  end

  // Request outputs.
  always_comb begin
    req_t s;
    s = '0;
    s.kind = KIND_STATUS;
    s.status = st;
    s.version = hver_next;
    req_valid = key_out || end_of_file;
    req_two = key_out && end_of_file;
    req0 = key_out ? key_req : s;
    req1 = s;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; bis <= '0; hver <= '0; bone_total <= '0;
      bones_left <= '0; dsize <= '0; keys_left <= '0; cur_bone <= '0;
      bcount <= '0; norm <= '0; any_key <= 1'b0; ferr <= ST_OK;
    end else if (accept) begin
      if (end_of_file) begin
        phase <= PH_HEADER; bis <= '0; hver <= '0; bone_total <= '0;
        bones_left <= '0; dsize <= '0; keys_left <= '0; cur_bone <= '0;
        bcount <= '0; norm <= '0; any_key <= 1'b0; ferr <= ST_OK;
      end else begin
        phase <= phase_next; bis <= bis_next; hver <= hver_next;
        bone_total <= bone_total_next; bones_left <= bones_left_next;
        dsize <= dsize_next; keys_left <= keys_left_next;
        cur_bone <= cur_bone_next; bcount <= bcount_next; norm <= norm_next;
        any_key <= any_key_next; ferr <= ferr_next;
      end
    end
  end

  // Key byte store.
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_KEY_S || phase == PH_KEY_R || phase == PH_KEY_P))
      kb[bis[3:0]] <= data_byte;
  end

endmodule

FILE: hw/rtl/acsp_queue.sv
// Request queue between the front and back ends.
module acsp_queue import acsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push2,
  input  logic push1,
  input  req_t in0,
  input  req_t in1,
  output logic room2,
  output logic pop_ok,
  input  logic take,
  output req_t head
);

  req_t       mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign room2  = cnt <= 3'd2;
  assign pop_ok = cnt != 3'd0;
  assign head   = mem[rp];

  // Storage writes, up to two per cycle.
  always_ff @(posedge clk) begin
    if (push1 || push2) mem[wp] <= in0;
    if (push2) mem[wp + 2'd1] <= in1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp  <= wp + (push2 ? 2'd2 : (push1 ? 2'd1 : 2'd0));
      rp  <= rp + {1'b0, take};
      cnt <= cnt + (push2 ? 3'd2 : (push1 ? 3'd1 : 3'd0)) - {2'd0, take};
    end
  end

endmodule

FILE: hw/rtl/acsp_back.sv
// Back end: converts half components and holds the result register.
module acsp_back import acsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  input  req_t        src,
  output logic        src_take,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [31:0] bone_id,
  output logic [15:0] time_ms,
  output logic [31:0] comp0,
  output logic [31:0] comp1,
  output logic [31:0] comp2,
  output logic [31:0] comp3,
  output logic [3:0]  status,
  output logic [7:0]  version,
  output logic        last
);

  logic full_q;

  assign empty    = !full_q;
  assign src_take = src_valid && (!full_q || pop);

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) full_q <= 1'b0;
    else if (src_take) full_q <= 1'b1;
    else if (pop) full_q <= 1'b0;
  end

  // Result payload with conversion to single precision.
  always_ff @(posedge clk) begin
    if (src_take) begin
      kind    <= src.kind;
      bone_id <= src.bone_id;
      time_ms <= src.time_ms;
      comp0   <= (src.kind == KIND_STATUS) ? 32'd0 : half_to_single(src.h0);
      comp1   <= (src.kind == KIND_STATUS) ? 32'd0 : half_to_single(src.h1);
      comp2   <= (src.kind == KIND_STATUS) ? 32'd0 : half_to_single(src.h2);
      comp3   <= (src.kind == KIND_ROTATION) ? half_to_single(src.h3) : 32'd0;
      status  <= src.status;
      version <= src.version;
      last    <= src.kind == KIND_STATUS;
    end
  end

endmodule

FILE: hw/rtl/animation_clip_stream_parser_top.sv
// Top level of the animation clip stream parser.
// The clip file enters one byte per request on data_byte, with end_of_file
// set on the final byte; a byte is taken when push is high and full is low.
// Results leave through a queue interface: while empty is low the oldest
// result is on the output ports and pop takes it.
// The front parser takes one byte per cycle while full is low and issues at
// most two per byte (a finished key, the file status) into a four-entry queue.
// The back end converts half components and registers the result; a key passes
// through the queue entry and then the result register to reach the result ports.
// Sustained rate is one byte per cycle while full is low; full rises only when
// the queue cannot take two more requests, which happens when the receiver stalls.
// Reset clears the parser to the header phase and empties the queue; after
// every end_of_file byte the parser returns to that same state.
module animation_clip_stream_parser_top import acsp_pkg::*; #(
  parameter int LENGTH_BITS = 34
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [31:0] bone_id,
  output logic [15:0] time_ms,
  output logic [31:0] comp0,
  output logic [31:0] comp1,
  output logic [31:0] comp2,
  output logic [31:0] comp3,
  output logic [3:0]  status,
  output logic [7:0]  version,
  output logic        last
);

  logic accept, rv, r2, room2, q_ok, q_take;
  req_t r0, r1, head;

  assign full   = !room2;
  assign accept = push && room2;

  acsp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst, .data_byte, .end_of_file, .accept,
    .req_valid(rv), .req_two(r2), .req0(r0), .req1(r1)
  );

  acsp_queue u_queue (
    .clk, .rst, .push2(accept && r2), .push1(accept && rv && !r2),
    .in0(r0), .in1(r1), .room2, .pop_ok(q_ok), .take(q_take), .head
  );

  acsp_back u_back (
    .clk, .rst, .src_valid(q_ok), .src(head), .src_take(q_take), .pop, .empty,
    .kind, .bone_id, .time_ms, .comp0, .comp1, .comp2, .comp3, .status,
    .version, .last
  );

endmodule

FILE: hw/rtl/acsp_checker.sv
// Port checker for the animation clip stream parser, bound to the top level.
module acsp_checker import acsp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [1:0] kind,
  input logic [3:0] status,
  input logic       last
);

  // A status result is exactly the one flagged last.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (kind == KIND_STATUS))) else $error("last flag mismatch");

  // Key results carry no status code.
  a_key_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_STATUS) |-> status == ST_OK) else $error("key with status");

  // Status codes stay in range.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> status <= ST_NO_KEYS) else $error("bad status code");

  // A held result does not change until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(status)))
    else $error("result changed while held");

  // After reset nothing is waiting and there is room for input.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result after reset");

endmodule

bind animation_clip_stream_parser_top acsp_checker u_acsp_checker (
  .clk, .rst, .full, .pop, .empty, .kind, .status, .last
);
